### design/hae_pkg.sv
// ============================================================================
// hae_pkg
// Shared types and character constants for the attribute escaper.
// ============================================================================
package hae_pkg;

    typedef enum logic [2:0] {
        K_PLAIN,
        K_AMP,
        K_LT,
        K_GT,
        K_QUOT,
        K_APOS,
        K_CTRL
    } t_kind;

    // data holds the raw byte for plain, or {tens, ones} digits for control
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [2:0] len;
    } t_entry;

    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_QUOT  = 8'h22;
    localparam logic [7:0] C_APOS  = 8'h27;
    localparam logic [7:0] C_HASH  = 8'h23;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_ZERO  = 8'h30;

endpackage

### design/hae_front.sv
// ============================================================================
// hae_front
// Accepts input bytes, classifies them and registers one queue entry.
// ============================================================================
module hae_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [7:0]      i_s_axis_tdata,   // [7:0] text_byte
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output hae_pkg::t_entry o_q_entry
);
    import hae_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic [1:0] tens;
    logic [3:0] ones;
    logic [7:0] c;

    assign c = i_s_axis_tdata;

    always_comb begin
        if (c >= 8'd30) begin
            tens = 2'd3;
        end else if (c >= 8'd20) begin
            tens = 2'd2;
        end else if (c >= 8'd10) begin
            tens = 2'd1;
        end else begin
            tens = 2'd0;
        end
        ones = 4'(c - 8'd10 * {6'd0, tens});
    end

    always_comb begin
        n_entry.kind = K_PLAIN;
        n_entry.data = c;
        n_entry.len  = 3'd1;
        if (c < C_SPACE && c != C_TAB) begin
            n_entry.kind = K_CTRL;
            n_entry.data = {2'b00, tens, ones};
            n_entry.len  = (tens != 2'd0) ? 3'd5 : 3'd4;
        end else begin
            case (c)
                C_AMP: begin
                    n_entry.kind = K_AMP;
                    n_entry.len  = 3'd5;
                end
                C_LT: begin
                    n_entry.kind = K_LT;
                    n_entry.len  = 3'd4;
                end
                C_GT: begin
                    n_entry.kind = K_GT;
                    n_entry.len  = 3'd4;
                end
                C_QUOT: begin
                    n_entry.kind = K_QUOT;
                    n_entry.len  = 3'd6;
                end
                C_APOS: begin
                    n_entry.kind = K_APOS;
                    n_entry.len  = 3'd5;
                end
                default: begin
                    n_entry.kind = K_PLAIN;
                end
            endcase
        end
    end

    assign o_s_axis_tready = !r_valid || i_q_ready;
    assign o_q_valid       = r_valid;
    assign o_q_entry       = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_entry <= n_entry;
        end
    end

endmodule

### design/hae_queue.sv
// ============================================================================
// hae_queue
// Small first-in first-out buffer of classified entries.
// ============================================================================
module hae_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  hae_pkg::t_entry i_wr_entry,
    output logic            o_rd_valid,
    input  logic            i_rd_ready,
    output hae_pkg::t_entry o_rd_entry
);
    import hae_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_entry            r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic              do_wr;
    logic              do_rd;

    assign o_wr_ready = r_count != CntW'(DEPTH);
    assign o_rd_valid = r_count != '0;
    assign o_rd_entry = r_mem[r_rd_ptr];
    assign do_wr      = i_wr_valid && o_wr_ready;
    assign do_rd      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

endmodule

### design/hae_back.sv
// ============================================================================
// hae_back
// Expands one entry into its output run, one byte per transfer.
// ============================================================================
module hae_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  hae_pkg::t_entry i_q_entry,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic            o_m_axis_tlast    // run_last
);
    import hae_pkg::*;

    logic       r_busy;
    t_entry     r_entry;
    logic [2:0] r_idx;
    logic       r_m_valid;
    logic [7:0] r_m_data;
    logic       r_m_last;
    logic       out_adv;
    logic       cur_last;
    logic [7:0] cur_byte;
    logic       load;

    function automatic logic [7:0] char_at(input t_entry e, input logic [2:0] idx);
        logic [7:0] tens_ch;
        logic [7:0] ones_ch;
        tens_ch = C_ZERO + {6'd0, e.data[5:4]};
        ones_ch = C_ZERO + {4'd0, e.data[3:0]};
        char_at = C_SEMI;
        case (e.kind)
            K_PLAIN: char_at = e.data;
            K_AMP: begin
                case (idx)
                    3'd0:    char_at = C_AMP;
                    3'd1:    char_at = 8'h61;
                    3'd2:    char_at = 8'h6D;
                    3'd3:    char_at = 8'h70;
                    default: char_at = C_SEMI;
                endcase
            end
            K_LT, K_GT: begin
                case (idx)
                    3'd0:    char_at = C_AMP;
                    3'd1:    char_at = (e.kind == K_LT) ? 8'h6C : 8'h67;
                    3'd2:    char_at = 8'h74;
                    default: char_at = C_SEMI;
                endcase
            end
            K_QUOT: begin
                case (idx)
                    3'd0:    char_at = C_AMP;
                    3'd1:    char_at = 8'h71;
                    3'd2:    char_at = 8'h75;
                    3'd3:    char_at = 8'h6F;
                    3'd4:    char_at = 8'h74;
                    default: char_at = C_SEMI;
                endcase
            end
            K_APOS: begin
                case (idx)
                    3'd0:    char_at = C_AMP;
                    3'd1:    char_at = C_HASH;
                    3'd2:    char_at = 8'h33;
                    3'd3:    char_at = 8'h39;
                    default: char_at = C_SEMI;
                endcase
            end
            K_CTRL: begin
                case (idx)
                    3'd0:    char_at = C_AMP;
                    3'd1:    char_at = C_HASH;
                    3'd2:    char_at = (e.len == 3'd5) ? tens_ch : ones_ch;
                    3'd3:    char_at = (e.len == 3'd5) ? ones_ch : C_SEMI;
                    default: char_at = C_SEMI;
                endcase
            end
            default: char_at = e.data;
        endcase
    endfunction

    assign out_adv   = !r_m_valid || i_m_axis_tready;
    assign cur_byte  = char_at(r_entry, r_idx);
    assign cur_last  = r_idx == (r_entry.len - 3'd1);
    assign o_q_ready = !r_busy || (out_adv && cur_last);
    assign load      = o_q_ready && i_q_valid;

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tlast  = r_m_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (out_adv) begin
                r_m_valid <= r_busy;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy && out_adv) begin
                if (cur_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
        if (out_adv && r_busy) begin
            r_m_data <= cur_byte;
            r_m_last <= cur_last;
        end
        if (load) begin
            r_entry <= i_q_entry;
        end
    end

endmodule

### design/html_attribute_escape.sv
// Throughput: plain bytes at one per cycle while the output accepts them; an
// escaped byte keeps the expander busy while it emits its 4 to 6 byte run.
// The entry queue absorbs input while a run drains.
// Reset (synchronous, active low) empties the front register, queue and output.
// ============================================================================
// html_attribute_escape
// HTML attribute entity escaper: one input byte to a run of 1..6 bytes.
// ============================================================================
module html_attribute_escape #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,    // [7:0] text_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,    // [7:0] out_byte
    output logic       o_m_axis_tlast     // run_last
);
    import hae_pkg::*;

    logic   fq_valid;
    logic   fq_ready;
    t_entry fq_entry;
    logic   qb_valid;
    logic   qb_ready;
    t_entry qb_entry;

    hae_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_q_valid       (fq_valid),
        .i_q_ready       (fq_ready),
        .o_q_entry       (fq_entry)
    );

    hae_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wr_entry (fq_entry),
        .o_rd_valid (qb_valid),
        .i_rd_ready (qb_ready),
        .o_rd_entry (qb_entry)
    );

    hae_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (qb_valid),
        .o_q_ready       (qb_ready),
        .i_q_entry       (qb_entry),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

### design/hae_checker.sv
// ============================================================================
// hae_checker
// Port-level checks on output runs of the attribute escaper.
// ============================================================================
module hae_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);
    import hae_pkg::*;

    logic [2:0] r_run;
    logic       m_xfer;

    assign m_xfer = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (m_xfer) begin
            r_run <= o_m_axis_tlast ? 3'd0 : r_run + 3'd1;
        end
    end

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_xfer && !o_m_axis_tlast) |-> (r_run < 3'd5))
        else $error("output run longer than six bytes");

    a_amp_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_xfer && o_m_axis_tdata == C_AMP) |-> (r_run == 3'd0 && !o_m_axis_tlast))
        else $error("ampersand not at the start of an entity run");

    a_entity_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_xfer && o_m_axis_tlast && r_run != 3'd0) |-> (o_m_axis_tdata == C_SEMI))
        else $error("multi-byte run does not end with a semicolon");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled output transfer changed");

endmodule

bind html_attribute_escape hae_checker u_hae_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
